FILE: hdl/kmst_pkg.sv
// kmst_pkg: shared constants, types and helpers for the keyed message stats table
// used by the channel interfaces and the top level
// no dependencies
`default_nettype none

package kmst_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int COUNT_BITS    = 32;

    // field widths of the channels
    localparam int MSG_TYPE_W  = 12;
    localparam int STATION_W   = 12;
    localparam int KEY_W       = MSG_TYPE_W + STATION_W;
    localparam int INDEX_OUT_W = 4;
    localparam int COUNT_OUT_W = 32;

    // derived widths
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_RAM_W = 3 * COUNT_BITS;

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MISS,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // one result transaction
    typedef struct packed {
        logic [INDEX_OUT_W-1:0] entry_index;
        logic                   new_entry;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] received_count;
        logic [COUNT_OUT_W-1:0] used_count;
        logic [COUNT_OUT_W-1:0] rejected_count;
    } result_t;

    // saturating increment
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/kmst_in_if.sv
// kmst_in_if: valid/ready channel carrying one message report
// depends on kmst_pkg for field widths
`default_nettype none

interface kmst_in_if;
    logic                          valid;
    logic                          ready;
    logic [kmst_pkg::MSG_TYPE_W-1:0] msg_type;
    logic [kmst_pkg::STATION_W-1:0]  station_id;
    logic                          used_flag;
    logic                          crc_failed_flag;

    modport source (
        output valid, msg_type, station_id, used_flag, crc_failed_flag,
        input  ready
    );

    modport sink (
        input  valid, msg_type, station_id, used_flag, crc_failed_flag,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/kmst_out_if.sv
// kmst_out_if: valid/ready channel carrying one table result
// depends on kmst_pkg for field widths
`default_nettype none

interface kmst_out_if;
    logic                             valid;
    logic                             ready;
    logic [kmst_pkg::INDEX_OUT_W-1:0] entry_index;
    logic                             new_entry;
    logic                             table_full;
    logic [kmst_pkg::COUNT_OUT_W-1:0] received_count;
    logic [kmst_pkg::COUNT_OUT_W-1:0] used_count;
    logic [kmst_pkg::COUNT_OUT_W-1:0] rejected_count;

    modport source (
        output valid, entry_index, new_entry, table_full,
               received_count, used_count, rejected_count,
        input  ready
    );

    modport sink (
        input  valid, entry_index, new_entry, table_full,
               received_count, used_count, rejected_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/keyed_message_stats_table_top.sv
// keyed_message_stats_table_top: per-key statistics table for correction messages
// depends on kmst_pkg, kmst_in_if, kmst_out_if and kmst_ram
//
// usage
//   report: one transaction per received message (type, station id, used flag,
//   checksum-failed flag). result: exactly one transaction per report with the
//   slot of the key, whether it was created, a table-full flag and the three
//   updated saturating counts of the entry; a full-table result has all else zero.
//   keys live in a key ram and the counts in a count ram, both with a registered
//   read. the search walks the key ram one slot per cycle from slot 0 up to the
//   fill count, so the search loop sets the latency. a hit goes through search,
//   update and result; a new key through search (skipped on an empty table),
//   miss, update and result; a full table through search, miss and result.
//   one report is worked at a time; report.ready is high only while the
//   sequencer is idle, again after the result is handed over, and the next
//   report can be taken while an earlier result still waits in the output register.
//   a stalled result holds in the output register; a second finished result
//   waits in the sequencer until the output register frees up.
//   reset clears the fill count, the sequencer and the output valid; the rams
//   are not cleared, since only slots below the fill count are ever used.
`default_nettype none

module keyed_message_stats_table_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kmst_in_if.sink    report,
    kmst_out_if.source result
);

    import kmst_pkg::*;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    key_t               key_reg, key_next;
    logic               used_reg, used_next;
    logic               bad_reg, bad_next;
    logic               new_reg, new_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    // ram ports
    logic                 key_we;
    logic [IDX_W-1:0]     key_waddr;
    logic [IDX_W-1:0]     key_raddr;
    key_t                 key_rdata;
    logic                 cnt_we;
    logic [IDX_W-1:0]     cnt_raddr;
    logic [CNT_RAM_W-1:0] cnt_wdata;
    logic [CNT_RAM_W-1:0] cnt_rdata;

    // count update
    count_t rcv_base, used_base, rej_base;
    count_t rcv_new, used_new, rej_new;
    logic   accept;
    logic   key_hit;
    logic   last_slot;

    kmst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kmst_ram #(
        .WIDTH (CNT_RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (idx_reg),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign accept    = report.valid && report.ready;
    assign key_hit   = (key_rdata == key_reg);
    assign last_slot = (({1'b0, idx_reg} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(fill_reg));

    // counts start at zero for a freshly allocated slot
    always_comb
    begin
        if (new_reg)
        begin
            rcv_base  = '0;
            used_base = '0;
            rej_base  = '0;
        end
        else
        begin
            rcv_base  = cnt_rdata[COUNT_BITS-1:0];
            used_base = cnt_rdata[2*COUNT_BITS-1:COUNT_BITS];
            rej_base  = cnt_rdata[3*COUNT_BITS-1:2*COUNT_BITS];
        end
        rcv_new  = sat_inc(rcv_base);
        used_new = used_reg ? sat_inc(used_base) : used_base;
        rej_new  = bad_reg ? sat_inc(rej_base) : rej_base;
        cnt_wdata = {rej_new, used_new, rcv_new};
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        key_next       = key_reg;
        used_next      = used_reg;
        bad_next       = bad_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        key_we         = 1'b0;
        key_waddr      = fill_reg[IDX_W-1:0];
        key_raddr      = '0;
        cnt_we         = 1'b0;
        cnt_raddr      = idx_reg;
        report.ready   = (state_reg == ST_IDLE);

        // output register drains
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                key_raddr = '0;
                if (accept)
                begin
                    key_next   = {report.msg_type, report.station_id};
                    used_next  = report.used_flag;
                    bad_next   = report.crc_failed_flag;
                    idx_next   = '0;
                    state_next = (fill_reg == '0) ? ST_MISS : ST_SEARCH;
                end
            end

            // key of slot idx_reg is on the ram output
            ST_SEARCH:
            begin
                if (key_hit)
                begin
                    cnt_raddr  = idx_reg;
                    new_next   = 1'b0;
                    state_next = ST_UPDATE;
                end
                else if (last_slot)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    key_raddr  = idx_reg + IDX_W'(1);
                end
            end

            // allocate the next free slot or report a full table
            ST_MISS:
            begin
                if (fill_reg == FILL_W'(TABLE_ENTRIES))
                begin
                    res_next            = '0;
                    res_next.table_full = 1'b1;
                    state_next          = ST_RESULT;
                end
                else
                begin
                    key_we     = 1'b1;
                    idx_next   = fill_reg[IDX_W-1:0];
                    fill_next  = fill_reg + FILL_W'(1);
                    new_next   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end

            // read-modify-write of the counts
            ST_UPDATE:
            begin
                cnt_we                  = 1'b1;
                res_next.entry_index    = INDEX_OUT_W'(idx_reg);
                res_next.new_entry      = new_reg;
                res_next.table_full     = 1'b0;
                res_next.received_count = COUNT_OUT_W'(rcv_new);
                res_next.used_count     = COUNT_OUT_W'(used_new);
                res_next.rejected_count = COUNT_OUT_W'(rej_new);
                state_next              = ST_RESULT;
            end

            // hand the result to the output register when it is free
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        used_reg     <= used_next;
        bad_reg      <= bad_next;
        new_reg      <= new_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // result channel
    assign result.valid          = out_valid_reg;
    assign result.entry_index    = out_data_reg.entry_index;
    assign result.new_entry      = out_data_reg.new_entry;
    assign result.table_full     = out_data_reg.table_full;
    assign result.received_count = out_data_reg.received_count;
    assign result.used_count     = out_data_reg.used_count;
    assign result.rejected_count = out_data_reg.rejected_count;

endmodule

`default_nettype wire

FILE: hdl/kmst_ram.sv
// kmst_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
